@@ sv/hcbt_pkg.sv @@
// Package for the chunked body tracker: line limit defaults, framing characters,
// phase and result types, and the hex digit decoder.
// No dependencies.
package hcbt_pkg;

   localparam int unsigned LINE_SPAN_BYTES = 8 * 1024;
   localparam logic [15:0] LINE_LIMIT_RESET = 16'(LINE_SPAN_BYTES - 1);

   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_9    = 8'h39;
   localparam logic [7:0] CHAR_LA   = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;
   localparam logic [7:0] CHAR_UA   = 8'h41;
   localparam logic [7:0] CHAR_UF   = 8'h46;

   typedef enum logic [4:0] {
      PH_LINE = 5'b00001,
      PH_DATA = 5'b00010,
      PH_TERM = 5'b00100,
      PH_DONE = 5'b01000,
      PH_FAIL = 5'b10000
   } phase_type;

   typedef struct packed {
      logic consumed;
      logic message_done;
      logic framing_error;
      logic payload_byte;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b0;
      h.value = 4'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         h.valid = 1'b1;
         h.value = 4'(c - CHAR_0);
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         h.valid = 1'b1;
         h.value = 4'(c - CHAR_LA + 8'd10);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         h.valid = 1'b1;
         h.value = 4'(c - CHAR_UA + 8'd10);
      end
      return h;
   endfunction

endpackage

@@ sv/http_chunked_body_tracker.sv @@
// Chunked message body tracker: one body byte in, one framing result out.
// Depends on hcbt_pkg.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | data_byte, start_of_message
//   rsp     | out       | rsp_valid/rsp_stall | consumed, message_done,
//           |           |                     | framing_error, payload_byte
//   csr     | in        | csr_valid/csr_ready | max_line_chars (16 bits)
//
// One byte per cycle while req does not stall; each result is registered before rsp.
// The 64-bit chunk counter decrement and compare set the per-cycle path.
// A two-entry output (result register plus skid register) keeps req open
// while one result waits; req stalls only when both hold a result.
// Reset is synchronous; it clears the tracking state and sets the line limit
// to 8191. csr is always ready.
module http_chunked_body_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_consumed,
   output logic        rsp_message_done,
   output logic        rsp_framing_error,
   output logic        rsp_payload_byte,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import hcbt_pkg::*;

   logic [15:0] max_line_ff;
   phase_type   phase_ff, phase_in;
   logic [63:0] left_ff, left_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] count_ff, count_in;
   logic        crlf_ff, crlf_in;
   logic        trailer_ff, trailer_in;
   logic        digit_ff, digit_in;
   logic        semi_ff, semi_in;
   logic        bad_ff, bad_in;

   phase_type   b_phase;
   logic [63:0] b_left, b_acc, left_dec;
   logic [15:0] b_count;
   logic        b_crlf, b_trailer, b_digit, b_semi, b_bad;
   logic        took, payload;
   hex_type     hex;
   result_type  res_in;

   result_type  out_ff, skid_ff;
   logic        out_valid_ff, skid_valid_ff;
   logic        accept, out_free;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_consumed      = out_ff.consumed;
   assign rsp_message_done  = out_ff.message_done;
   assign rsp_framing_error = out_ff.framing_error;
   assign rsp_payload_byte  = out_ff.payload_byte;

   always_comb begin
      b_phase   = req_start_of_message ? PH_LINE : phase_ff;
      b_left    = req_start_of_message ? 64'd0 : left_ff;
      b_acc     = req_start_of_message ? 64'd0 : acc_ff;
      b_count   = req_start_of_message ? 16'd0 : count_ff;
      b_crlf    = req_start_of_message ? 1'b0 : crlf_ff;
      b_trailer = req_start_of_message ? 1'b0 : trailer_ff;
      b_digit   = req_start_of_message ? 1'b0 : digit_ff;
      b_semi    = req_start_of_message ? 1'b0 : semi_ff;
      b_bad     = req_start_of_message ? 1'b0 : bad_ff;

      phase_in   = b_phase;
      left_in    = b_left;
      acc_in     = b_acc;
      count_in   = b_count;
      crlf_in    = b_crlf;
      trailer_in = b_trailer;
      digit_in   = b_digit;
      semi_in    = b_semi;
      bad_in     = b_bad;
      took       = 1'b0;
      payload    = 1'b0;
      hex        = hex_decode(req_data_byte);
      left_dec   = (b_left != 64'd0) ? b_left - 64'd1 : b_left;

      case (b_phase)
         PH_LINE: begin
            if (req_data_byte == CHAR_LF) begin
               if (!b_trailer && (b_bad || !b_digit)) begin
                  phase_in = PH_FAIL;
               end else begin
                  if (!b_trailer) begin
                     if (b_acc == 64'd0) begin
                        trailer_in = 1'b1;
                     end else begin
                        left_in  = b_acc;
                        phase_in = PH_DATA;
                     end
                  end else if (b_count == 16'd0) begin
                     phase_in = PH_DONE;
                  end
                  count_in = 16'd0;
                  digit_in = 1'b0;
                  semi_in  = 1'b0;
                  bad_in   = 1'b0;
                  acc_in   = 64'd0;
                  took     = 1'b1;
               end
            end else if (req_data_byte == CHAR_CR) begin
               took = 1'b1;
            end else if (b_count >= max_line_ff) begin
               phase_in = PH_FAIL;
            end else begin
               count_in = b_count + 16'd1;
               took     = 1'b1;
               if (!b_trailer && !b_semi) begin
                  if (req_data_byte == CHAR_SEMI) begin
                     semi_in = 1'b1;
                  end else if (hex.valid) begin
                     acc_in   = {b_acc[59:0], hex.value};
                     digit_in = 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
            end
         end
         PH_DATA: begin
            took    = 1'b1;
            payload = 1'b1;
            left_in = left_dec;
            if (left_dec == 64'd0) begin
               phase_in = PH_TERM;
            end
         end
         PH_TERM: begin
            if (req_data_byte == (b_crlf ? CHAR_LF : CHAR_CR)) begin
               took = 1'b1;
               if (b_crlf) begin
                  crlf_in  = 1'b0;
                  phase_in = PH_LINE;
               end else begin
                  crlf_in = 1'b1;
               end
            end else begin
               phase_in = PH_FAIL;
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_FAIL;
         end
      endcase

      res_in.consumed      = took;
      res_in.message_done  = (phase_in == PH_DONE);
      res_in.framing_error = (phase_in == PH_FAIL);
      res_in.payload_byte  = payload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= LINE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         max_line_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LINE;
         left_ff    <= 64'd0;
         acc_ff     <= 64'd0;
         count_ff   <= 16'd0;
         crlf_ff    <= 1'b0;
         trailer_ff <= 1'b0;
         digit_ff   <= 1'b0;
         semi_ff    <= 1'b0;
         bad_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         left_ff    <= left_in;
         acc_ff     <= acc_in;
         count_ff   <= count_in;
         crlf_ff    <= crlf_in;
         trailer_ff <= trailer_in;
         digit_ff   <= digit_in;
         semi_ff    <= semi_in;
         bad_ff     <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_free) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_free) begin
            out_ff <= res_in;
         end else begin
            skid_ff <= res_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the result register is empty");

   a_done_or_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_message_done && rsp_framing_error))
      else $error("result flags both message end and framing error");

   a_payload_consumed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload_byte) |-> (rsp_consumed && !rsp_framing_error))
      else $error("payload byte not consumed or flagged as error");

   a_error_not_consumed: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_in == PH_FAIL) |=> !out_ff.consumed || skid_valid_ff)
      else $error("error byte reported as consumed");
`endif

endmodule
